/* rtl/smq_pkg.sv */
package smq_pkg;

    // Sizes of the value range and of the stack
    localparam int VALUE_LIMIT = 1024;
    localparam int STACK_DEPTH = 1024;

    // Field and storage widths
    localparam int FIELD_W = 11;
    localparam int TREE_AW = $clog2(VALUE_LIMIT);
    localparam int STK_AW  = $clog2(STACK_DEPTH);
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    // tree index and walk position, wide enough for limit plus lowbit
    localparam int IDX_W   = $clog2(2 * VALUE_LIMIT + 1);
    // largest power of two not above the value limit
    localparam int TOP_STEP = 1 << ($clog2(VALUE_LIMIT + 1) - 1);

    // Action codes
    localparam logic [1:0] ACT_PUSH   = 2'd0;
    localparam logic [1:0] ACT_POP    = 2'd1;
    localparam logic [1:0] ACT_MEDIAN = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [FIELD_W-1:0] push_value;
    } query_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] result_value;
    } reply_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic clr_step;
        logic push_wr;
        logic pop_rd;
        logic pop_cap;
        logic add_init;
        logic add_step;
        logic walk_init;
        logic walk_step;
        logic finish;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] act;
        logic       err;
        logic       clr_last;
        logic       add_last;
        logic       walk_last;
    } dp_stat_t;

endpackage

/* rtl/smq_ctrl.sv */
module smq_ctrl
    import smq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_POP_CAP,
        S_ADD_INIT,
        S_ADD,
        S_WALK,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.err)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    case (stat.act)
                        ACT_PUSH:
                        begin
                            cmd.push_wr  = 1'b1;
                            cmd.add_init = 1'b1;
                            state_next   = S_ADD;
                        end
                        ACT_POP:
                        begin
                            cmd.pop_rd = 1'b1;
                            state_next = S_POP_CAP;
                        end
                        ACT_MEDIAN:
                        begin
                            cmd.walk_init = 1'b1;
                            state_next    = S_WALK;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_POP_CAP:
            begin
                cmd.pop_cap = 1'b1;
                state_next  = S_ADD_INIT;
            end
            S_ADD_INIT:
            begin
                cmd.add_init = 1'b1;
                state_next   = S_ADD;
            end
            S_ADD:
            begin
                cmd.add_step = 1'b1;
                if (stat.add_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next != S_IDLE);
    end

    // State and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

/* rtl/smq_dp.sv */
module smq_dp
    import smq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  dp_cmd_t  cmd,
    input  query_t   query,
    output dp_stat_t stat,
    output logic     reply_valid,
    output reply_t   reply
);

    // Stack and count tree storage
    logic [FIELD_W-1:0] stk_mem  [STACK_DEPTH];
    logic [CNT_W-1:0]   tree_mem [VALUE_LIMIT];

    logic [1:0]         act_reg;
    logic [1:0]         code_reg, code_next;
    logic [FIELD_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [IDX_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic [TREE_AW-1:0] clr_reg;
    logic               reply_valid_reg;
    reply_t             reply_reg, reply_next;

    logic [FIELD_W-1:0] stk_rdata_reg;
    logic [CNT_W-1:0]   tree_rdata_reg;

    logic               tree_we, tree_re;
    logic [TREE_AW-1:0] tree_waddr, tree_raddr;
    logic [CNT_W-1:0]   tree_wdata;
    logic               stk_we, stk_re;
    logic [STK_AW-1:0]  stk_addr;

    logic [IDX_W-1:0]   lowbit, idx_up;
    logic [IDX_W-1:0]   nxt, walk_pos, walk_step, walk_nxt;
    logic               take;
    logic [CNT_W-1:0]   cnt_dec;
    logic [IDX_W-1:0]   raw_ext, med_pos;
    logic [FIELD_W-1:0] sat_val;

    // Fenwick update and walk arithmetic
    always_comb
    begin
        lowbit   = idx_reg & (~idx_reg + 1'b1);
        idx_up   = idx_reg + lowbit;
        nxt      = pos_reg + step_reg;
        take     = (nxt <= IDX_W'(VALUE_LIMIT)) && (tree_rdata_reg < left_reg);
        walk_pos = take ? nxt : pos_reg;
        walk_step = step_reg >> 1;
        walk_nxt = walk_pos + walk_step;
        cnt_dec  = count_reg - 1'b1;
        raw_ext  = IDX_W'(query.push_value);
        med_pos  = pos_reg + 1'b1;
        if (med_pos > IDX_W'(VALUE_LIMIT))
        begin
            med_pos = IDX_W'(VALUE_LIMIT);
        end
        // push value saturates into 1..limit
        if (query.push_value == '0)
        begin
            sat_val = FIELD_W'(1);
        end
        else if (raw_ext > IDX_W'(VALUE_LIMIT))
        begin
            sat_val = FIELD_W'(VALUE_LIMIT);
        end
        else
        begin
            sat_val = query.push_value;
        end
    end

    // Register updates and memory port control
    always_comb
    begin
        code_next  = code_reg;
        val_next   = val_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        step_next  = step_reg;
        left_next  = left_reg;
        tree_we    = 1'b0;
        tree_waddr = clr_reg;
        tree_wdata = '0;
        tree_re    = 1'b0;
        tree_raddr = '0;
        stk_we     = 1'b0;
        stk_re     = 1'b0;
        stk_addr   = count_reg[STK_AW-1:0];
        reply_next = reply_reg;

        if (cmd.load)
        begin
            val_next  = sat_val;
            code_next = ST_OK;
            if (query.action == ACT_PUSH)
            begin
                if (count_reg >= CNT_W'(STACK_DEPTH))
                begin
                    code_next = ST_FULL;
                end
            end
            else if (query.action inside {ACT_POP, ACT_MEDIAN})
            begin
                if (count_reg == '0)
                begin
                    code_next = ST_EMPTY;
                end
            end
        end

        if (cmd.clr_step)
        begin
            tree_we = 1'b1;
        end

        if (cmd.push_wr)
        begin
            stk_we     = 1'b1;
            count_next = count_reg + 1'b1;
        end

        if (cmd.pop_rd)
        begin
            stk_re     = 1'b1;
            stk_addr   = cnt_dec[STK_AW-1:0];
            count_next = cnt_dec;
        end

        if (cmd.pop_cap)
        begin
            val_next = stk_rdata_reg;
        end

        // first tree node of an update is the value itself
        if (cmd.add_init)
        begin
            idx_next   = IDX_W'(val_reg);
            tree_re    = 1'b1;
            tree_raddr = TREE_AW'(IDX_W'(val_reg) - 1'b1);
        end

        // write this node, read the next one up the tree
        if (cmd.add_step)
        begin
            tree_we    = 1'b1;
            tree_waddr = TREE_AW'(idx_reg - 1'b1);
            tree_wdata = (act_reg == ACT_PUSH) ? tree_rdata_reg + 1'b1
                                               : tree_rdata_reg - 1'b1;
            idx_next   = idx_up;
            tree_re    = (idx_up <= IDX_W'(VALUE_LIMIT));
            tree_raddr = TREE_AW'(idx_up - 1'b1);
        end

        if (cmd.walk_init)
        begin
            pos_next   = '0;
            step_next  = IDX_W'(TOP_STEP);
            left_next  = CNT_W'((IDX_W'(count_reg) + 1'b1) >> 1);
            tree_re    = 1'b1;
            tree_raddr = TREE_AW'(TOP_STEP - 1);
        end

        // one binary-lifting step per cycle
        if (cmd.walk_step)
        begin
            pos_next   = walk_pos;
            step_next  = walk_step;
            left_next  = take ? left_reg - tree_rdata_reg : left_reg;
            tree_re    = (walk_step != '0) && (walk_nxt <= IDX_W'(VALUE_LIMIT));
            tree_raddr = TREE_AW'(walk_nxt - 1'b1);
        end

        if (cmd.finish)
        begin
            reply_next.status       = code_reg;
            reply_next.result_value = '0;
            if (code_reg == ST_OK)
            begin
                if (act_reg == ACT_POP)
                begin
                    reply_next.result_value = val_reg;
                end
                else if (act_reg == ACT_MEDIAN)
                begin
                    reply_next.result_value = FIELD_W'(med_pos);
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            clr_reg         <= '0;
            reply_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            reply_valid_reg <= cmd.finish;
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= query.action;
        end
        code_reg  <= code_next;
        val_reg   <= val_next;
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        step_reg  <= step_next;
        left_reg  <= left_next;
        reply_reg <= reply_next;
    end

    // Count tree memory
    always_ff @(posedge clk)
    begin
        if (tree_we)
        begin
            tree_mem[tree_waddr] <= tree_wdata;
        end
        if (tree_re)
        begin
            tree_rdata_reg <= tree_mem[tree_raddr];
        end
    end

    // Stack memory
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_addr] <= val_reg;
        end
        if (stk_re)
        begin
            stk_rdata_reg <= stk_mem[stk_addr];
        end
    end

    // Status back to the controller
    always_comb
    begin
        stat.act       = act_reg;
        stat.err       = (code_reg != ST_OK);
        stat.clr_last  = (clr_reg == {TREE_AW{1'b1}});
        stat.add_last  = (idx_up > IDX_W'(VALUE_LIMIT));
        stat.walk_last = (step_reg == IDX_W'(1));
    end

    assign reply_valid = reply_valid_reg;
    assign reply       = reply_reg;

endmodule

/* rtl/stack_with_median_query_core.sv */
// Channel   Handshake              Payload
// query     start high, busy low   query_t  {action, push_value}
// reply     reply_valid, 1 cycle   reply_t  {status, result_value}
//
// One reply per query, strobed in the first cycle that busy is low again.
// Push: one step per Fenwick node touched, after the dispatch; pop: a stack
// read and capture come first; median: one binary-lifting step per count
// tree read. Errors and the unused action go from dispatch straight to finish.
// After reset busy stays high while the count tree is cleared.
// The reply cannot be held off; it is valid for exactly one cycle.
module stack_with_median_query_core
    import smq_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  query_t query,
    output logic   busy,
    output logic   reply_valid,
    output reply_t reply
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    smq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    smq_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .query       (query),
        .stat        (stat),
        .reply_valid (reply_valid),
        .reply       (reply)
    );

endmodule

/* tb/sv/tb_stack_with_median_query_core.sv */
`timescale 1ns / 1ps

module tb_stack_with_median_query_core
    import smq_pkg::*;
();

    // Predicts one reply per accepted query and checks the replies in order
    class median_stack_scoreboard;

        logic [FIELD_W-1:0] stack_vals [STACK_DEPTH];
        int                 depth;
        int                 value_hits [VALUE_LIMIT+1];
        reply_t             replies_due [$];
        int                 failures;

        function new();
            depth    = 0;
            failures = 0;
            foreach (value_hits[k])
                value_hits[k] = 0;
        endfunction

        function int level();
            return depth;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        // only the first ten failures are printed
        function void flag(string msg);
            failures++;
            if (failures <= 10)
                $display("%s", msg);
        endfunction

        // Reply for one query; updates the stack and the per-value counts
        function reply_t predict_reply(query_t q);
            reply_t             r;
            logic [FIELD_W-1:0] v;
            int                 rank;
            int                 running;
            r.status       = ST_OK;
            r.result_value = '0;
            case (q.action)
                ACT_PUSH:
                begin
                    if (depth >= STACK_DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        // out-of-range values saturate into 1..VALUE_LIMIT
                        if (q.push_value == 0)
                            v = FIELD_W'(1);
                        else if (q.push_value > VALUE_LIMIT)
                            v = FIELD_W'(VALUE_LIMIT);
                        else
                            v = q.push_value;
                        stack_vals[depth] = v;
                        depth++;
                        value_hits[v]++;
                    end
                end
                ACT_POP:
                begin
                    if (depth == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        depth--;
                        r.result_value = stack_vals[depth];
                        value_hits[stack_vals[depth]]--;
                    end
                end
                ACT_MEDIAN:
                begin
                    if (depth == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        // smallest value whose running count reaches the rank
                        rank    = (depth + 1) / 2;
                        running = 0;
                        for (int k = 1; k <= VALUE_LIMIT && running < rank; k++)
                        begin
                            running += value_hits[k];
                            if (running >= rank)
                                r.result_value = FIELD_W'(k);
                        end
                    end
                end
                default:
                    ;
            endcase
            return r;
        endfunction

        function void note_query(query_t q);
            replies_due.push_back(predict_reply(q));
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (replies_due.size() == 0)
            begin
                flag($sformatf("%0t: reply with nothing outstanding: status %0d value %0d",
                               $realtime, got.status, got.result_value));
                return;
            end
            want = replies_due.pop_front();
            if (got.status !== want.status || got.result_value !== want.result_value)
                flag($sformatf("%0t: mismatch, status exp %0d got %0d, value exp %0d got %0d",
                               $realtime, want.status, got.status,
                               want.result_value, got.result_value));
        endfunction
    endclass

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 20;

    logic   clk;
    logic   rst_n;
    logic   start;
    query_t query;
    logic   busy;
    logic   reply_valid;
    reply_t reply;

    median_stack_scoreboard sb;
    int calm_left;
    int idle_cycles;

    stack_with_median_query_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .query       (query),
        .busy        (busy),
        .reply_valid (reply_valid),
        .reply       (reply)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // reply monitor
    always @(posedge clk)
    begin
        if (rst_n && reply_valid)
            sb.check_reply(reply);
    end

    // watchdog: cycles with neither an item accepted nor a reply
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || reply_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, and bursts with none
    function int pick_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm_left = int'($urandom_range(10, 40));
            return 0;
        end
        r = int'($urandom_range(0, 99));
        if (r < 50)
            return 0;
        else if (r < 85)
            return int'($urandom_range(1, 3));
        else if (r < 97)
            return int'($urandom_range(4, 12));
        else
            return int'($urandom_range(20, 60));
    endfunction

    // push values: edges, out-of-range, clustered duplicates, full range
    function logic [FIELD_W-1:0] pick_value();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 4)
            return '0;
        else if (r < 8)
            return FIELD_W'($urandom_range(VALUE_LIMIT + 1, 2047));
        else if (r < 12)
            return FIELD_W'(VALUE_LIMIT);
        else if (r < 16)
            return FIELD_W'(1);
        else if (r < 40)
            return FIELD_W'($urandom_range(1, 16));
        else
            return FIELD_W'($urandom_range(1, VALUE_LIMIT));
    endfunction

    // drive one item, hold until accepted, then idle for a random gap, which may be zero
    task automatic send_query(logic [1:0] act, logic [FIELD_W-1:0] val);
        query_t q;
        int     gap;
        q.action     = act;
        q.push_value = val;
        start <= 1'b1;
        query <= q;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_query(q);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off until every outstanding reply is in
    task automatic wait_drained();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // random mix by percent; the rest of 100 goes to the unused action
    task automatic random_items(int count, bit until_full, int w_push, int w_pop,
                                int w_med);
        int n;
        int r;
        n = 0;
        while (until_full ? sb.level() < STACK_DEPTH : n < count)
        begin
            r = int'($urandom_range(0, 99));
            if (r < w_push)
                send_query(ACT_PUSH, pick_value());
            else if (r < w_push + w_pop)
                send_query(ACT_POP, FIELD_W'($urandom_range(0, 2047)));
            else if (r < w_push + w_pop + w_med)
                send_query(ACT_MEDIAN, FIELD_W'($urandom_range(0, 2047)));
            else
                send_query(ACT_UNUSED, FIELD_W'($urandom_range(0, 2047)));
            n++;
        end
    endtask

    initial
    begin
        sb          = new();
        calm_left   = 0;
        idle_cycles = 0;
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        query       = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty stack, saturation, unused action, small medians
        send_query(ACT_MEDIAN, 11'd0);
        send_query(ACT_POP, 11'h7FF);
        send_query(ACT_UNUSED, 11'd5);
        send_query(ACT_PUSH, 11'd0);
        send_query(ACT_PUSH, 11'd1);
        send_query(ACT_PUSH, 11'd1024);
        send_query(ACT_PUSH, 11'd1025);
        send_query(ACT_PUSH, 11'd2047);
        send_query(ACT_PUSH, 11'd512);
        send_query(ACT_MEDIAN, 11'h7FF);
        send_query(ACT_POP, 11'd0);
        send_query(ACT_MEDIAN, 11'd0);
        send_query(ACT_UNUSED, 11'h7FF);
        send_query(ACT_POP, 11'd0);
        send_query(ACT_POP, 11'd0);
        send_query(ACT_MEDIAN, 11'd0);
        send_query(ACT_POP, 11'd0);
        send_query(ACT_POP, 11'd0);
        send_query(ACT_POP, 11'd0);
        send_query(ACT_PUSH, 11'h555);
        send_query(ACT_PUSH, 11'h2AA);
        send_query(ACT_MEDIAN, 11'd0);
        send_query(ACT_POP, 11'd0);
        send_query(ACT_POP, 11'd0);
        send_query(ACT_MEDIAN, 11'd0);
        wait_drained();

        // random: churn near empty, fill to full, work at full, churn again
        random_items(60, 1'b0, 40, 27, 28);
        wait_drained();
        random_items(0, 1'b1, 93, 1, 6);
        wait_drained();
        random_items(30, 1'b0, 40, 25, 30);
        random_items(30, 1'b0, 20, 50, 25);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.flag($sformatf("%0d replies never arrived", sb.pending()));
        if (sb.failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
